>>> rtl/core/farc_pkg.sv
// Shared types, codes and port widths for the frame-aged reuse cache.
package farc_pkg;

  localparam int KEY_W      = 64;
  localparam int HIN_W      = 16;
  localparam int IN_DATA_W  = KEY_W + HIN_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 4;
  localparam int STATUS_W   = 3;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVICT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd5;

  localparam logic [1:0] AGE_OLD = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LCMP,
    S_LMOV,
    S_TSTART,
    S_TCHK,
    S_TEV,
    S_TMOV,
    S_TADV,
    S_TNEXT,
    S_RES
  } state_t;

  typedef enum logic {
    RD_LAST,
    RD_IDX_M1
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_INS,
    WR_AGED,
    WR_MOVED
  } wr_src_t;

  typedef struct packed {
    logic                cap;
    logic                idx_load;
    logic                idx_dec;
    logic                pool_wr;
    logic                pool_val;
    logic                rd_en;
    rd_src_t             rd_src;
    logic                wr_en;
    wr_src_t             wr_src;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                hold_handle;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       pool_one;
    logic       cnt_zero;
    logic       full;
    logic       idx_zero;
    logic       idx_is_last;
    logic       hit;
    logic       old;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/core/farc_ctrl.sv
// Sequencing controller for lookups, inserts and frame ticks.
module farc_ctrl
  import farc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.req)
          REQ_LOOKUP: begin
            if (sts.cnt_zero) begin
              code_nxt  = ST_MISS;
              state_nxt = S_RES;
            end else begin
              state_nxt = S_LCMP;
            end
          end
          REQ_INSERT: begin
            code_nxt  = sts.full ? ST_FULL : ST_INSERT;
            state_nxt = S_RES;
          end
          REQ_TICK: state_nxt = S_TSTART;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_LCMP: begin
        if (sts.hit) begin
          code_nxt  = ST_HIT;
          state_nxt = sts.idx_is_last ? S_RES : S_LMOV;
        end else if (sts.idx_zero) begin
          code_nxt  = ST_MISS;
          state_nxt = S_RES;
        end
      end
      S_LMOV: state_nxt = S_RES;
      S_TSTART: begin
        state_nxt = sts.cnt_zero ? S_TNEXT : S_TCHK;
      end
      S_TCHK: begin
        if (sts.old) begin
          state_nxt = S_TEV;
        end else if (sts.idx_zero) begin
          state_nxt = S_TNEXT;
        end
      end
      S_TEV: begin
        if (sts.out_free) state_nxt = sts.idx_is_last ? S_TADV : S_TMOV;
      end
      S_TMOV: state_nxt = S_TADV;
      S_TADV: state_nxt = sts.idx_zero ? S_TNEXT : S_TCHK;
      S_TNEXT: begin
        if (sts.pool_one) begin
          code_nxt  = ST_DONE;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_TSTART;
        end
      end
      S_RES: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_src     = RD_LAST;
    cmd.wr_src     = WR_INS;
    cmd.out_status = code_r;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_DISP: begin
        case (sts.req)
          REQ_LOOKUP: begin
            if (!sts.cnt_zero) begin
              cmd.rd_en    = 1'b1;
              cmd.rd_src   = RD_LAST;
              cmd.idx_load = 1'b1;
            end
          end
          REQ_INSERT: begin
            if (!sts.full) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WR_INS;
              cmd.cnt_inc = 1'b1;
            end
          end
          REQ_TICK: begin
            cmd.pool_wr  = 1'b1;
            cmd.pool_val = 1'b0;
          end
          default: ;
        endcase
      end
      S_LCMP: begin
        if (sts.hit) begin
          cmd.hold_handle = 1'b1;
          if (sts.idx_is_last) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_LAST;
          end
        end else if (!sts.idx_zero) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_IDX_M1;
          cmd.idx_dec = 1'b1;
        end
      end
      S_LMOV, S_TMOV: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_MOVED;
        cmd.cnt_dec = 1'b1;
      end
      S_TSTART: begin
        if (!sts.cnt_zero) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_src   = RD_LAST;
          cmd.idx_load = 1'b1;
        end
      end
      S_TCHK: begin
        if (sts.old) begin
          cmd.hold_handle = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_AGED;
          if (!sts.idx_zero) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_src  = RD_IDX_M1;
            cmd.idx_dec = 1'b1;
          end
        end
      end
      S_TEV: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_EVICT;
          cmd.out_last   = 1'b0;
          if (sts.idx_is_last) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_LAST;
          end
        end
      end
      S_TADV: begin
        if (!sts.idx_zero) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_IDX_M1;
          cmd.idx_dec = 1'b1;
        end
      end
      S_TNEXT: begin
        if (!sts.pool_one) begin
          cmd.pool_wr  = 1'b1;
          cmd.pool_val = 1'b1;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = code_r;
          cmd.out_last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/farc_dp.sv
// Datapath with the entry memory, pool counts, scan index and result register.
module farc_dp
  import farc_pkg::*;
#(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam int HW = (HANDLE_BITS < HIN_W) ? HANDLE_BITS : HIN_W;
  localparam int IW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam int MD = 2 ** AW;
  localparam int EW = KEY_W + HW + 2;

  logic [EW-1:0]       mem [MD];
  logic [EW-1:0]       rdata_r;
  logic [1:0]          req_r;
  logic                pool_r;
  logic [KEY_W-1:0]    key_r;
  logic [HW-1:0]       hin_r;
  logic [IW-1:0]       idx_r;
  logic [CW-1:0]       cnt_r [2];
  logic [CW-1:0]       cnt_sel;
  logic [CW-1:0]       cnt_m1;
  logic [HW-1:0]       res_handle_r;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [1:0]          rd_age;
  logic [HW-1:0]       rd_handle;
  logic [KEY_W-1:0]    rd_key;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HW-1:0]       out_handle_r;
  logic                out_pool_r;
  logic                out_last_r;
  logic                out_free;

  assign cnt_sel   = cnt_r[pool_r];
  assign cnt_m1    = cnt_sel - CW'(1);
  assign rd_age    = rdata_r[1:0];
  assign rd_handle = rdata_r[HW+1:2];
  assign rd_key    = rdata_r[EW-1:HW+2];
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (cmd.rd_src)
      RD_LAST:   rd_addr = {pool_r, cnt_m1[IW-1:0]};
      RD_IDX_M1: rd_addr = {pool_r, idx_r - IW'(1)};
      default:   rd_addr = {pool_r, idx_r};
    endcase
  end

  always_comb begin
    case (cmd.wr_src)
      WR_INS: begin
        wr_addr = {pool_r, cnt_sel[IW-1:0]};
        wr_data = {key_r, hin_r, 2'd0};
      end
      WR_AGED: begin
        wr_addr = {pool_r, idx_r};
        wr_data = {rd_key, rd_handle, rd_age + 2'd1};
      end
      default: begin
        wr_addr = {pool_r, idx_r};
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r  <= in_tuser[1:0];
      pool_r <= in_tuser[2];
      key_r  <= in_tdata[KEY_W-1:0];
      hin_r  <= in_tdata[KEY_W +: HW];
    end else if (cmd.pool_wr) begin
      pool_r <= cmd.pool_val;
    end
    if (cmd.idx_load) begin
      idx_r <= cnt_m1[IW-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - IW'(1);
    end
    if (cmd.hold_handle) res_handle_r <= rd_handle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r[pool_r] <= cnt_sel + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r[pool_r] <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      out_handle_r <= (cmd.out_status == ST_HIT || cmd.out_status == ST_EVICT) ?
                      res_handle_r : '0;
      out_pool_r   <= (cmd.out_status == ST_DONE) ? 1'b0 : pool_r;
    end
  end

  assign sts.req         = req_r;
  assign sts.pool_one    = pool_r;
  assign sts.cnt_zero    = (cnt_sel == '0);
  assign sts.full        = (cnt_sel == CW'(POOL_DEPTH));
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.idx_is_last = (CW'(idx_r) == cnt_m1);
  assign sts.hit         = (rd_key == key_r) && rd_age[1];
  assign sts.old         = (rd_age == AGE_OLD);
  assign sts.out_free    = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_handle_r);
  assign out_tuser  = {out_pool_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/frame_aged_reuse_cache_top.sv
// Frame-aged reuse cache: two pools of released allocations with deferred free.
// One request is taken at a time and in_tready is high only while the block is idle.
// All entries live in one memory with one read and one write port, and the scan
// reads one entry per cycle while no eviction waits on the result register. A lookup
// scans up to POOL_DEPTH entries and a hit moves the last entry into its slot; a frame
// tick visits every entry in both pools and evicts the old ones. Results go through a
// single output register, so a stalled result consumer stretches a tick.
module frame_aged_reuse_cache_top
  import farc_pkg::*;
#(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key_hash[63:0], handle_in[79:64]
  input  logic [IN_USER_W-1:0]  in_tuser,   // req_type[1:0], pool_sel[2]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // handle_out[15:0]
  output logic [OUT_USER_W-1:0] out_tuser,  // status[2:0], pool_out[3]
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  farc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  farc_dp #(
    .POOL_DEPTH  (POOL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a result is still pending");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_src == WR_INS) |-> !sts.full)
    else $error("insert written into a full pool");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.cnt_zero)
    else $error("entry removed from an empty pool");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !cmd.out_load)
    else $error("result issued in the cycle after a request transfer");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame-aged reuse cache: directed and random requests.
import farc_pkg::*;

localparam int CACHE_DEPTH = 16;
localparam logic [1:0] REQ_NONE = 2'd3;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [15:0]         handle;
  logic                pool;
  logic                last;
} cache_result_t;

class reuse_cache_shadow;
  logic [63:0]   keys [2][CACHE_DEPTH];
  logic [15:0]   handles [2][CACHE_DEPTH];
  logic [1:0]    ages [2][CACHE_DEPTH];
  int            fill [2];
  cache_result_t pending_results [$];
  int            mismatches;

  function new();
    fill[0] = 0;
    fill[1] = 0;
    mismatches = 0;
  endfunction

  function void push_result(logic [STATUS_W-1:0] st, logic [15:0] h, logic p, logic l);
    cache_result_t r;
    r.status = st;
    r.handle = h;
    r.pool = p;
    r.last = l;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // The last entry of the pool moves into the freed slot.
  function void remove_entry(int p, int i);
    int tail;
    tail = fill[p] - 1;
    keys[p][i] = keys[p][tail];
    handles[p][i] = handles[p][tail];
    ages[p][i] = ages[p][tail];
    fill[p] = tail;
  endfunction

  function void note_request(logic [1:0] req, logic pool, logic [63:0] key, logic [15:0] hin);
    int idx;
    int q;
    bit found;
    found = 1'b0;
    case (req)
      REQ_LOOKUP: begin
        for (idx = fill[pool] - 1; idx >= 0 && !found; idx--) begin
          if (keys[pool][idx] == key && ages[pool][idx] > 2'd1) begin
            push_result(ST_HIT, handles[pool][idx], pool, 1'b1);
            remove_entry(pool, idx);
            found = 1'b1;
          end
        end
        if (!found) begin
          push_result(ST_MISS, '0, pool, 1'b1);
        end
      end
      REQ_INSERT: begin
        if (fill[pool] >= CACHE_DEPTH) begin
          push_result(ST_FULL, '0, pool, 1'b1);
        end else begin
          keys[pool][fill[pool]] = key;
          handles[pool][fill[pool]] = hin;
          ages[pool][fill[pool]] = 2'd0;
          fill[pool] = fill[pool] + 1;
          push_result(ST_INSERT, '0, pool, 1'b1);
        end
      end
      REQ_TICK: begin
        for (q = 0; q < 2; q++) begin
          for (idx = fill[q] - 1; idx >= 0; idx--) begin
            if (ages[q][idx] >= AGE_OLD) begin
              push_result(ST_EVICT, handles[q][idx], q[0], 1'b0);
              remove_entry(q, idx);
            end
          end
        end
        for (q = 0; q < 2; q++) begin
          for (idx = 0; idx < fill[q]; idx++) begin
            if (ages[q][idx] != AGE_OLD) begin
              ages[q][idx] = ages[q][idx] + 2'd1;
            end
          end
        end
        push_result(ST_DONE, '0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [STATUS_W-1:0] st, logic [15:0] h, logic p, logic l);
    cache_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d, handle_out %h, pool_out %0d", st, h, p);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (st !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, st);
      mismatches++;
    end
    if (h !== want.handle) begin
      $error("handle_out: expected %h, got %h", want.handle, h);
      mismatches++;
    end
    if (p !== want.pool) begin
      $error("pool_out: expected %0d, got %0d", want.pool, p);
      mismatches++;
    end
    if (l !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, l);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  reuse_cache_shadow shadow_cache = new();
  int          send_idle_pct = 36;
  int          recv_idle_pct = 48;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  logic [63:0] key_bank [8];

  frame_aged_reuse_cache_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic [1:0] req, input logic pool, input logic [63:0] key,
                           input logic [15:0] hin);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hin, key};
    in_tuser <= {pool, req};
    do @(posedge clk); while (!in_tready);
    shadow_cache.note_request(req, pool, key, hin);
  endtask

  // Keys mostly come from a small bank so that lookups find aged entries.
  task automatic send_random_item(input int tick_pct, input int insert_pct);
    int          roll;
    logic        pool;
    logic [1:0]  req;
    logic [63:0] key;
    roll = $urandom_range(0, 99);
    pool = 1'($urandom_range(0, 1));
    key = key_bank[$urandom_range(0, 7)];
    if (roll < 3) begin
      req = REQ_NONE;
      key = random_key();
    end else if (roll < 3 + tick_pct) begin
      req = REQ_TICK;
    end else if (roll < 3 + tick_pct + insert_pct) begin
      req = REQ_INSERT;
      if ($urandom_range(0, 99) < 30) begin
        key = random_key();
        key_bank[$urandom_range(0, 7)] = key;
      end
    end else begin
      req = REQ_LOOKUP;
      if ($urandom_range(0, 99) < 15) begin
        key = random_key();
      end
    end
    send_item(req, pool, key, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        shadow_cache.check_result(out_tuser[2:0], out_tdata[15:0], out_tuser[3], out_tlast);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    int phase;
    int drain_cycles;
    key_bank[0] = '0;
    key_bank[1] = '1;
    for (n = 2; n < 8; n++) begin
      key_bank[n] = random_key();
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(REQ_LOOKUP, 1'b1, '1, 16'h0000);
    send_item(REQ_INSERT, 1'b0, '0, 16'h0000);
    send_item(REQ_INSERT, 1'b0, '1, 16'hffff);
    send_item(REQ_LOOKUP, 1'b0, '0, 16'hffff);
    send_item(REQ_TICK, 1'b0, '0, 16'h0000);
    send_item(REQ_LOOKUP, 1'b0, '1, 16'h0000);
    send_item(REQ_TICK, 1'b1, '1, 16'hffff);
    send_item(REQ_LOOKUP, 1'b0, '1, 16'h0000);
    send_item(REQ_NONE, 1'b1, '1, 16'hffff);
    for (n = 0; n < CACHE_DEPTH; n++) begin
      send_item(REQ_INSERT, 1'b1, key_bank[n % 8], 16'($urandom_range(0, 65535)));
    end
    send_item(REQ_INSERT, 1'b1, random_key(), 16'hffff);
    send_item(REQ_TICK, 1'b0, '0, 16'h0000);
    send_item(REQ_TICK, 1'b0, '0, 16'h0000);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 48;
        recv_idle_pct = 36;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < 84; n++) begin
        if (phase == 0 && n == 40) begin
          hold_request = 1'b1;
        end
        if (phase == 1 && n == 50) begin
          in_tvalid <= 1'b0;
          while (shadow_cache.pending_results.size() != 0) @(posedge clk);
        end
        if (phase == 1) begin
          send_random_item(5, 60);
        end else begin
          send_random_item(12, 40);
        end
      end
    end
    in_tvalid <= 1'b0;

    drain_cycles = 0;
    while (shadow_cache.pending_results.size() != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (200) @(posedge clk);
    if (shadow_cache.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", shadow_cache.pending_results.size());
      shadow_cache.mismatches++;
    end
    if (shadow_cache.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
